FILE: src/ctst_pkg.sv
// Package for the class-table string trimmer.
// Holds the item structs, register indexes, buffer sizing and the command and
// status structs shared by the controller and the datapath.
package ctst_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [63:0] CLASS_0_RESET = 64'h0000_0001_0000_3600;
  localparam logic [2:0]  TRIM_MODE_RESET = 3'b111;

  localparam int MODE_LEAD  = 0;
  localparam int MODE_INNER = 1;
  localparam int MODE_TRAIL = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASS_0   = 3'd0,
    CFG_CLASS_1   = 3'd1,
    CFG_CLASS_2   = 3'd2,
    CFG_CLASS_3   = 3'd3,
    CFG_TRIM_MODE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
    logic       pending_overflow;
  } res_item_t;

  typedef enum logic [1:0] {
    LOAD_NONE  = 2'd0,
    LOAD_NOW   = 2'd1,
    LOAD_DRAIN = 2'd2,
    LOAD_TAIL  = 2'd3
  } load_sel_e;

  typedef struct packed {
    logic               accept;
    load_sel_e          load_sel;
    logic               run_end;
    logic [PEND_AW-1:0] rd_addr;
  } ctst_cmd_t;

  typedef struct packed {
    logic               can_load;
    logic               now_result;
    logic               need_drain;
    logic [PEND_CW-1:0] drain_len;
    logic               tail_byte;
  } ctst_stat_t;

endpackage

FILE: src/ctst_datapath.sv
// Datapath of the string trimmer: class table, mode, string state, pending
// buffer memory and the result register. Uses ctst_pkg; driven by ctst_ctrl.
module ctst_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ctst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctst_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ctst_pkg::src_item_t            src_item,
  input  logic                           res_stall,
  output logic                           res_valid,
  output ctst_pkg::res_item_t            res_item,
  input  ctst_pkg::ctst_cmd_t            cmd,
  output ctst_pkg::ctst_stat_t           stat
);
  import ctst_pkg::*;

  logic [63:0] class_0;
  logic [63:0] class_1;
  logic [63:0] class_2;
  logic [63:0] class_3;
  logic [2:0]  trim_mode;

  logic               front;
  logic [PEND_CW-1:0] pend_count;
  logic               pend_ovf;
  logic [7:0]         pend_mem [PENDING_DEPTH];
  logic [7:0]         rd_data;

  logic [7:0] hold_byte;
  logic       hold_last;
  logic       hold_ovf;

  logic [255:0]       class_tbl;
  logic               trim;
  logic               hold_mode;
  logic               emit;
  logic               has_room;
  logic               push;
  logic               ovf_item;
  logic               pre_drain;
  logic               post_drain;
  logic [PEND_CW-1:0] count_after;
  logic               can_load;

  assign class_tbl = {class_3, class_2, class_1, class_0};
  assign trim      = class_tbl[src_item.in_byte];
  assign hold_mode = trim_mode[MODE_INNER] | trim_mode[MODE_TRAIL];
  assign has_room  = pend_count < PEND_CW'(PENDING_DEPTH);

  always_comb begin
    emit        = 1'b1;
    push        = 1'b0;
    ovf_item    = pend_ovf;
    pre_drain   = 1'b0;
    count_after = '0;
    if (trim) begin
      count_after = pend_count;
      if (front) begin
        emit = ~trim_mode[MODE_LEAD];
      end else if (hold_mode) begin
        emit = 1'b0;
        push = has_room;
        if (!has_room) begin
          ovf_item = 1'b1;
        end
        count_after = pend_count + PEND_CW'(push);
      end
    end else begin
      pre_drain = ~front & (pend_count != '0) & ~trim_mode[MODE_INNER];
    end
    post_drain = src_item.in_last & (count_after != '0) & ~trim_mode[MODE_TRAIL];
  end

  assign can_load        = ~res_valid | ~res_stall;
  assign stat.can_load   = can_load;
  assign stat.need_drain = pre_drain | post_drain;
  assign stat.drain_len  = pre_drain ? pend_count : count_after;
  assign stat.tail_byte  = emit & pre_drain;
  assign stat.now_result = (emit & ~pre_drain) |
                           (src_item.in_last & ~emit & ~pre_drain & ~post_drain);

  always_ff @(posedge clk) begin
    if (rst) begin
      class_0   <= CLASS_0_RESET;
      class_1   <= '0;
      class_2   <= '0;
      class_3   <= '0;
      trim_mode <= TRIM_MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLASS_0:   class_0   <= cfg_data;
        CFG_CLASS_1:   class_1   <= cfg_data;
        CFG_CLASS_2:   class_2   <= cfg_data;
        CFG_CLASS_3:   class_3   <= cfg_data;
        CFG_TRIM_MODE: trim_mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front      <= 1'b1;
      pend_count <= '0;
      pend_ovf   <= 1'b0;
    end else if (cmd.accept) begin
      if (src_item.in_last) begin
        front      <= 1'b1;
        pend_count <= '0;
        pend_ovf   <= 1'b0;
      end else begin
        front      <= front & trim;
        pend_count <= count_after;
        pend_ovf   <= ovf_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && push) begin
      pend_mem[pend_count[PEND_AW-1:0]] <= src_item.in_byte;
    end
    rd_data <= pend_mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_byte <= src_item.in_byte;
      hold_last <= src_item.in_last;
      hold_ovf  <= ovf_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_sel != LOAD_NONE) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.load_sel)
      LOAD_NOW: begin
        res_item.out_byte         <= emit ? src_item.in_byte : 8'd0;
        res_item.byte_valid       <= emit;
        res_item.run_last         <= ~post_drain;
        res_item.string_end       <= src_item.in_last & ~post_drain;
        res_item.pending_overflow <= ovf_item;
      end
      LOAD_DRAIN: begin
        res_item.out_byte         <= rd_data;
        res_item.byte_valid       <= 1'b1;
        res_item.run_last         <= cmd.run_end;
        res_item.string_end       <= cmd.run_end & hold_last;
        res_item.pending_overflow <= hold_ovf;
      end
      LOAD_TAIL: begin
        res_item.out_byte         <= hold_byte;
        res_item.byte_valid       <= 1'b1;
        res_item.run_last         <= 1'b1;
        res_item.string_end       <= hold_last;
        res_item.pending_overflow <= hold_ovf;
      end
      LOAD_NONE: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= PEND_CW'(PENDING_DEPTH))
    else $error("Pending count exceeds the buffer depth.");

  a_front_empty: assert property (@(posedge clk) disable iff (rst)
    front |-> (pend_count == '0))
    else $error("Bytes are held while no retained byte has been seen.");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && src_item.in_last) |=> (front && pend_count == '0 && !pend_ovf))
    else $error("String state not cleared after the final byte.");

endmodule

FILE: src/ctst_ctrl.sv
// Controller of the string trimmer: accepts items and sequences the release
// of held runs from the pending buffer. Uses ctst_pkg; drives ctst_datapath.
module ctst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  ctst_pkg::ctst_stat_t stat,
  output ctst_pkg::ctst_cmd_t  cmd
);
  import ctst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_DRAIN = 4'b0100,
    S_TAIL  = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [PEND_AW-1:0] idx;
  logic [PEND_AW-1:0] idx_next;
  logic [PEND_CW-1:0] len;
  logic [PEND_CW-1:0] len_next;
  logic               tail;
  logic               tail_next;
  logic               final_entry;

  assign final_entry = PEND_CW'(idx) == (len - PEND_CW'(1));
  assign src_stall   = ~((state == S_IDLE) & stat.can_load);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    len_next     = len;
    tail_next    = tail;
    cmd.accept   = 1'b0;
    cmd.load_sel = LOAD_NONE;
    cmd.run_end  = 1'b0;
    cmd.rd_addr  = '0;
    unique case (state)
      S_IDLE: begin
        if (src_valid && stat.can_load) begin
          cmd.accept   = 1'b1;
          cmd.load_sel = stat.now_result ? LOAD_NOW : LOAD_NONE;
          if (stat.need_drain) begin
            len_next   = stat.drain_len;
            tail_next  = stat.tail_byte;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        idx_next   = '0;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.rd_addr = idx;
        if (stat.can_load) begin
          cmd.load_sel = LOAD_DRAIN;
          cmd.run_end  = final_entry & ~tail;
          if (final_entry) begin
            state_next = tail ? S_TAIL : S_IDLE;
          end else begin
            idx_next    = idx + PEND_AW'(1);
            cmd.rd_addr = idx + PEND_AW'(1);
          end
        end
      end
      S_TAIL: begin
        if (stat.can_load) begin
          cmd.load_sel = LOAD_TAIL;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      len   <= '0;
      tail  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      len   <= len_next;
      tail  <= tail_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_sel != LOAD_NONE) |-> stat.can_load)
    else $error("Result register loaded while its item is still stalled.");

  a_fetch_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |=> (state == S_DRAIN && idx == '0))
    else $error("Buffer fetch not followed by a drain from the first entry.");

  a_drain_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (len != '0 && PEND_CW'(idx) < len))
    else $error("Drain index outside the held run.");

endmodule

FILE: src/class_table_string_trim.sv
// Top level of the class-table string trimmer.
// Joins ctst_ctrl and ctst_datapath; types and constants come from ctst_pkg.
//
//   channel   handshake                 payload
//   config    cfg_we                    cfg_index, cfg_data
//   source    src_valid / src_stall     src_item (in_byte, in_last)
//   result    res_valid / res_stall     res_item (trimmed byte and flags)
//
// An item that releases no held run leaves the controller in S_IDLE. An item
// that releases a held run passes S_FETCH, the registered read of the pending
// buffer, S_DRAIN for each run byte and S_TAIL when a kept byte follows.
// Reset is synchronous and restores the class table, the mode and the string
// state. A stalled result holds the result register and the next item waits.
module class_table_string_trim (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ctst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctst_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           src_valid,
  output logic                           src_stall,
  input  ctst_pkg::src_item_t            src_item,
  output logic                           res_valid,
  input  logic                           res_stall,
  output ctst_pkg::res_item_t            res_item
);
  import ctst_pkg::*;

  ctst_cmd_t  cmd;
  ctst_stat_t stat;

  ctst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ctst_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_item  (src_item),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_item  (res_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
